>>> hw/rtl/ifhg_pkg.sv
// ----------------------------------------------------------------------------
// ifhg_pkg
// Shared types and constants of the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
package ifhg_pkg;

    // Register file
    localparam int PaddrW = 3;
    localparam logic RegMtu    = 1'b0;
    localparam logic RegSrcAdr = 1'b1;
    localparam logic [13:0] MtuReset = 14'd1500;
    localparam logic [31:0] SrcReset = 32'd0;

    // Header constants
    localparam logic [13:0] MtuFloor   = 14'd1100;
    localparam logic [15:0] EthHdr     = 16'd14;
    localparam logic [15:0] IpHdr      = 16'd20;
    localparam logic [15:0] HdrBytes   = 16'd34;
    localparam logic [7:0]  TtlValue   = 8'd128;
    localparam logic [7:0]  VerIhl     = 8'h45;
    localparam logic [15:0] IdentReset = 16'd1000;
    localparam int          MoreFragBit = 13;

    // Width of the unfolded partial header sum
    localparam int SumW = 19;

    // Job queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [15:0] frame_length;
        logic [31:0] dest_addr;
        logic [7:0]  protocol;
    } in_item_t;

    typedef struct packed {
        logic [13:0] frag_field;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [15:0] header_checksum;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [13:0] mtu;
        logic [31:0] source_addr;
    } cfg_t;

    typedef struct packed {
        logic [15:0]     identification;
        logic [15:0]     chunk;
        logic [15:0]     remaining;
        logic [SumW-1:0] partial;
    } job_t;

    typedef struct packed {
        logic [13:0]     frag_field;
        logic [15:0]     total_length;
        logic [15:0]     identification;
        logic [15:0]     payload_offset;
        logic [15:0]     payload_length;
        logic            last;
        logic [SumW-1:0] partial;
    } frag_t;

endpackage

>>> hw/rtl/ifhg_regs.sv
// ----------------------------------------------------------------------------
// ifhg_regs
// APB-style configuration registers: link MTU and IPv4 source address.
// ----------------------------------------------------------------------------
module ifhg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ifhg_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ifhg_pkg::cfg_t              cfg
);
    import ifhg_pkg::*;

    logic [13:0] mtu_reg;
    logic [31:0] src_reg;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // Write on the access phase of a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg <= MtuReset;
            src_reg <= SrcReset;
        end else if (wr_en) begin
            case (reg_idx)
                RegMtu:    mtu_reg <= pwdata[13:0];
                RegSrcAdr: src_reg <= pwdata;
                default:   mtu_reg <= mtu_reg;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            RegMtu:    prdata = {18'd0, mtu_reg};
            RegSrcAdr: prdata = src_reg;
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.mtu         = mtu_reg;
    assign cfg.source_addr = src_reg;

endmodule

>>> hw/rtl/ifhg_front.sv
// ----------------------------------------------------------------------------
// ifhg_front
// Accept a datagram descriptor, assign its identification and classify it:
// chunk size, payload bytes and the fixed part of the header sum.
// ----------------------------------------------------------------------------
module ifhg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  ifhg_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  ifhg_pkg::in_item_t s_data,
    output logic               push_valid,
    input  logic               push_ready,
    output ifhg_pkg::job_t     push_data
);
    import ifhg_pkg::*;

    logic [15:0] ident_reg;
    logic [15:0] ident_next;
    logic [13:0] mtu_eff;
    logic [13:0] mtu_room;
    logic [15:0] flen_eff;
    logic [15:0] remaining;
    logic        fits;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign ident_next = ident_reg + 16'd1;

    // Advance the identification counter once per accepted descriptor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg <= IdentReset;
        end else if (s_valid && push_ready) begin
            ident_reg <= ident_next;
        end
    end

    // Clamp inputs and size the chunks; a frame that fits is one chunk
    always_comb begin
        mtu_eff   = (cfg.mtu < MtuFloor) ? MtuFloor : cfg.mtu;
        flen_eff  = (s_data.frame_length < HdrBytes) ? HdrBytes : s_data.frame_length;
        fits      = flen_eff <= {2'd0, mtu_eff};
        remaining = flen_eff - HdrBytes;
        mtu_room  = mtu_eff - HdrBytes[13:0];

        push_data.identification = ident_next;
        push_data.remaining      = remaining;
        push_data.chunk          = fits ? remaining : {2'd0, mtu_room[13:3], 3'd0};
        push_data.partial        = SumW'({VerIhl, 8'd0})
                                 + SumW'({TtlValue, s_data.protocol})
                                 + SumW'(cfg.source_addr[31:16])
                                 + SumW'(cfg.source_addr[15:0])
                                 + SumW'(s_data.dest_addr[31:16])
                                 + SumW'(s_data.dest_addr[15:0]);
    end

endmodule

>>> hw/rtl/ifhg_queue.sv
// ----------------------------------------------------------------------------
// ifhg_queue
// Short job queue that decouples descriptor intake from header output.
// ----------------------------------------------------------------------------
module ifhg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  ifhg_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ifhg_pkg::job_t pop_data
);
    import ifhg_pkg::*;

    job_t             entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != QCntW'(QDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCntW'(QDepth))
        else $error("job queue occupancy out of range");

endmodule

>>> hw/rtl/ifhg_back.sv
// ----------------------------------------------------------------------------
// ifhg_back
// Cut a job into fragments, one per cycle unless the output stalls, then
// checksum each header into the output register.
// ----------------------------------------------------------------------------
module ifhg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  ifhg_pkg::job_t    pop_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ifhg_pkg::result_t m_data
);
    import ifhg_pkg::*;

    // Fragment sequencer
    logic        busy_reg;
    job_t        job_reg;
    logic [15:0] rem_reg;
    logic [15:0] off_reg;
    logic [15:0] len;
    logic [15:0] rem_next;
    frag_t       frag_next;

    // Fragment stage and output register
    logic        fv_reg;
    frag_t       frag_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_load;
    logic        frag_adv;

    logic [SumW-1:0] sum0;
    logic [16:0]     sum1;
    logic [15:0]     sum2;
    result_t         out_next;

    assign out_load  = !out_valid_reg || m_ready;
    assign frag_adv  = !fv_reg || out_load;
    assign pop_ready = !busy_reg;

    // Size the current fragment
    always_comb begin
        len      = (job_reg.chunk < rem_reg) ? job_reg.chunk : rem_reg;
        rem_next = rem_reg - len;

        frag_next.frag_field     = {rem_next != 16'd0, off_reg[15:3]};
        frag_next.total_length   = len + IpHdr;
        frag_next.identification = job_reg.identification;
        frag_next.payload_offset = off_reg;
        frag_next.payload_length = len;
        frag_next.last           = rem_next == 16'd0;
        frag_next.partial        = job_reg.partial;
    end

    // Load a job, then step through its fragments
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (!busy_reg) begin
            busy_reg <= pop_valid;
        end else if (frag_adv) begin
            busy_reg <= rem_next != 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            job_reg <= pop_data;
            rem_reg <= pop_data.remaining;
            off_reg <= 16'd0;
        end else if (frag_adv) begin
            rem_reg <= rem_next;
            off_reg <= off_reg + len;
        end
    end

    // Fragment stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (frag_adv) begin
            fv_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (frag_adv && busy_reg) begin
            frag_reg <= frag_next;
        end
    end

    // Finish the ones-complement header sum
    always_comb begin
        sum0 = frag_reg.partial
             + SumW'(frag_reg.total_length)
             + SumW'(frag_reg.identification)
             + SumW'(frag_reg.frag_field);
        sum1 = {1'b0, sum0[15:0]} + 17'(sum0[SumW-1:16]);
        sum2 = sum1[15:0] + 16'(sum1[16]);

        out_next.frag_field      = frag_reg.frag_field;
        out_next.total_length    = frag_reg.total_length;
        out_next.identification  = frag_reg.identification;
        out_next.header_checksum = ~sum2;
        out_next.payload_offset  = frag_reg.payload_offset;
        out_next.payload_length  = frag_reg.payload_length;
        out_next.last            = frag_reg.last;
    end

    // Output register; hold while the result transfer stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= fv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && fv_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_mf_vs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fv_reg |-> (frag_reg.frag_field[MoreFragBit] == !frag_reg.last))
        else $error("more-fragments flag disagrees with last");

    a_len_match: assert property (@(posedge aclk) disable iff (!aresetn)
        fv_reg |-> (frag_reg.total_length == frag_reg.payload_length + IpHdr))
        else $error("total length does not match payload length");

    a_job_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> (fv_reg && frag_reg.last))
        else $error("job ended without a final fragment");

endmodule

>>> hw/rtl/ipv4_fragment_header_generator.sv
// A descriptor's first header follows the job queue entry, job register,
// fragment stage and output register when the queue is empty and the
// fragment sequencer idle. A datagram cut into n headers (1..62) holds the
// sequencer until its last header, one header per cycle unless m_ready
// stalls; a two-entry job queue lets further descriptors transfer meanwhile.
// Reset: identification counter 1000, MTU 1500, source address 0, queue empty.
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator
// Top level: registers, descriptor front end, job queue and header back end.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ifhg_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ifhg_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ifhg_pkg::result_t           m_data
);
    import ifhg_pkg::*;

    cfg_t cfg;
    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    ifhg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifhg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ifhg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ifhg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
